// ===== hw/rtl/pnrms_pkg.sv =====
// package: widths, constants, quantity slot maps and helpers for the running mean block
package pnrms_pkg;

   localparam int NODES_DEF = 4096;
   localparam int QUANTITIES_DEF = 11;
   localparam int NQ = 11;
   localparam int NODE_W = 12;
   localparam int SAMPLE_W = 32;
   localparam int MEAN_W = 64;
   localparam int COUNT_W = 32;
   localparam int DIM_W = 2;
   localparam int QIDX_W = 4;
   localparam int SLOT_W = 4;

   localparam logic [DIM_W-1:0] DIM_2D = 2'd2;
   localparam logic [DIM_W-1:0] DIM_RESET = 2'd3;

   // quantity codes in output order
   localparam logic [QIDX_W-1:0] Q_U = 4'd0;
   localparam logic [QIDX_W-1:0] Q_V = 4'd1;
   localparam logic [QIDX_W-1:0] Q_W = 4'd2;
   localparam logic [QIDX_W-1:0] Q_UU = 4'd3;
   localparam logic [QIDX_W-1:0] Q_VV = 4'd4;
   localparam logic [QIDX_W-1:0] Q_WW = 4'd5;
   localparam logic [QIDX_W-1:0] Q_UV = 4'd6;
   localparam logic [QIDX_W-1:0] Q_UW = 4'd7;
   localparam logic [QIDX_W-1:0] Q_VW = 4'd8;
   localparam logic [QIDX_W-1:0] Q_P = 4'd9;
   localparam logic [QIDX_W-1:0] Q_PP = 4'd10;
   localparam logic [QIDX_W-1:0] Q_LAST = 4'd10;

   typedef struct packed {
      logic             used;
      logic [SLOT_W-1:0] slot;
   } slot_type;

   // table slot of a quantity; w terms have no slot in 2D
   function automatic slot_type slot_of(input logic [QIDX_W-1:0] q, input logic two_d);
      slot_type s;
      s.used = 1'b1;
      s.slot = q;
      if (two_d) begin
         case (q) inside
            Q_U, Q_V: s.slot = q;
            Q_UU: s.slot = 4'd2;
            Q_VV: s.slot = 4'd3;
            Q_UV: s.slot = 4'd4;
            Q_P: s.slot = 4'd5;
            Q_PP: s.slot = 4'd6;
            default: begin
               s.used = 1'b0;
               s.slot = '0;
            end
         endcase
      end
      return s;
   endfunction

   typedef struct packed {
      logic              start;
      logic [MEAN_W-1:0] old_mean;
      logic [MEAN_W-1:0] sample;
      logic [COUNT_W-1:0] count;
   } upd_req_type;

endpackage

// ===== hw/rtl/pnrms_if.sv =====
// valid/ready channel interfaces for request and response transactions
interface pnrms_req_if;
   import pnrms_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [NODE_W-1:0]          node_index;
   logic signed [SAMPLE_W-1:0] vel_u;
   logic signed [SAMPLE_W-1:0] vel_v;
   logic signed [SAMPLE_W-1:0] vel_w;
   logic signed [SAMPLE_W-1:0] pressure;
   logic                       last_of_step;
   modport source (output valid, node_index, vel_u, vel_v, vel_w, pressure, last_of_step,
                   input ready);
   modport sink (input valid, node_index, vel_u, vel_v, vel_w, pressure, last_of_step,
                 output ready);
endinterface

interface pnrms_rsp_if;
   import pnrms_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [NODE_W-1:0]        out_node;
   logic signed [MEAN_W-1:0] mean_u;
   logic signed [MEAN_W-1:0] mean_v;
   logic signed [MEAN_W-1:0] mean_w;
   logic signed [MEAN_W-1:0] mean_uu;
   logic signed [MEAN_W-1:0] mean_vv;
   logic signed [MEAN_W-1:0] mean_ww;
   logic signed [MEAN_W-1:0] mean_uv;
   logic signed [MEAN_W-1:0] mean_uw;
   logic signed [MEAN_W-1:0] mean_vw;
   logic signed [MEAN_W-1:0] mean_p;
   logic signed [MEAN_W-1:0] mean_pp;
   modport source (output valid, out_node, mean_u, mean_v, mean_w, mean_uu, mean_vv, mean_ww,
                   mean_uv, mean_uw, mean_vw, mean_p, mean_pp, input ready);
   modport sink (input valid, out_node, mean_u, mean_v, mean_w, mean_uu, mean_vv, mean_ww,
                 mean_uv, mean_uw, mean_vw, mean_p, mean_pp, output ready);
endinterface

// ===== hw/rtl/per_node_running_mean_stats.sv =====
// top level: per-node cumulative mean of flow statistics
//
//  port group | dir | transaction
//  req_       | in  | node index, u v w p samples, last_of_step
//  rsp_       | out | node index and eleven updated means
//  csr_       | in  | dimension register write
//
//  transaction: accept, prep, one update per stored quantity (fewer in 2D), response;
//  the updates share one bit-serial divider (96 quotient bits per quantity)
//  each stored quantity: read, start, update; with count zero the sample is the result
//  the prep steps form the seven products and reduce the node index to a row
//  reset is synchronous; mean table has no reset and the user must write it before read
//  req_ready is low from accept until the response transaction is taken
module per_node_running_mean_stats #(
   parameter int NODES = pnrms_pkg::NODES_DEF,
   parameter int QUANTITIES = pnrms_pkg::QUANTITIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   pnrms_req_if.sink                     req,
   pnrms_rsp_if.source                   rsp,
   input  logic                          csr_wr_en,
   input  logic [pnrms_pkg::DIM_W-1:0]   csr_wr_data
);
   import pnrms_pkg::*;

   localparam int DEPTH = NODES * QUANTITIES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int NPROD = 7;
   localparam int PREP_W = $clog2(NODE_W);
   localparam logic [31:0] ROW_SUB0 = 32'(NODES) << (NODE_W - 1);

   typedef enum logic [2:0] {S_IDLE, S_PROD, S_READ, S_WAIT, S_UPD, S_RESP} state_type;

   state_type                  state_ff;
   logic [DIM_W-1:0]           dim_ff;
   logic [COUNT_W-1:0]         step_ff;
   logic [NODE_W-1:0]          node_ff;
   logic signed [SAMPLE_W-1:0] u_ff, v_ff, w_ff, p_ff;
   logic                       last_ff;
   logic                       two_d_ff;
   logic [QIDX_W-1:0]          q_ff;
   logic [MEAN_W-1:0]          x_ff [NQ];
   logic [MEAN_W-1:0]          mean_ff [NQ];
   logic [PREP_W-1:0]          prep_ff;
   logic [NODE_W-1:0]          row_ff;
   logic [31:0]                sub_ff;
   logic [ADDR_W-1:0]          row_base_ff;
   logic                       rsp_valid_ff;
   logic                       upd_start_ff;

   slot_type                   cur_slot;
   logic                       has_store;
   logic [ADDR_W-1:0]          ram_addr;
   logic [MEAN_W-1:0]          ram_rd;
   logic                       ram_we;
   upd_req_type                upd_req;
   logic                       upd_done;
   logic [MEAN_W-1:0]          upd_res;
   logic [QIDX_W-1:0]          prod_q;
   logic signed [SAMPLE_W-1:0] mul_a, mul_b;
   logic signed [MEAN_W-1:0]   prod_full;
   logic [NODE_W-1:0]          row_next;

   // current quantity's slot; slots beyond QUANTITIES read zero and drop writes
   assign cur_slot = slot_of(q_ff, two_d_ff);
   assign has_store = cur_slot.used && (32'(cur_slot.slot) < QUANTITIES);
   assign ram_addr = row_base_ff + ADDR_W'(cur_slot.slot);
   assign ram_we = (state_ff == S_UPD) && upd_done && has_store;

   // node modulo NODES by restoring reduction, one shifted compare per prep cycle
   assign row_next = (32'(row_ff) >= sub_ff) ? row_ff - NODE_W'(sub_ff) : row_ff;

   pnrms_ram #(.WIDTH(MEAN_W), .DEPTH(DEPTH)) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(upd_res),
      .rd_data(ram_rd)
   );

   assign upd_req.start = upd_start_ff;
   assign upd_req.old_mean = has_store ? ram_rd : '0;
   assign upd_req.sample = x_ff[q_ff];
   assign upd_req.count = step_ff;

   pnrms_update u_update (
      .clock (clock),
      .reset (reset),
      .req   (upd_req),
      .done  (upd_done),
      .result(upd_res)
   );

   // product formed in each prep cycle: squares, cross terms, then pressure squared
   always_comb begin
      case (prep_ff)
         4'd0: prod_q = Q_UU;
         4'd1: prod_q = Q_VV;
         4'd2: prod_q = Q_WW;
         4'd3: prod_q = Q_UV;
         4'd4: prod_q = Q_UW;
         4'd5: prod_q = Q_VW;
         default: prod_q = Q_PP;
      endcase
   end

   // one shared 32x32 signed multiplier for the seven products (w forced to zero in 2D)
   always_comb begin
      case (prod_q)
         Q_UU: begin mul_a = u_ff; mul_b = u_ff; end
         Q_VV: begin mul_a = v_ff; mul_b = v_ff; end
         Q_WW: begin mul_a = w_ff; mul_b = w_ff; end
         Q_UV: begin mul_a = u_ff; mul_b = v_ff; end
         Q_UW: begin mul_a = u_ff; mul_b = w_ff; end
         Q_VW: begin mul_a = v_ff; mul_b = w_ff; end
         default: begin mul_a = p_ff; mul_b = p_ff; end
      endcase
   end
   assign prod_full = mul_a * mul_b;

   always_ff @(posedge clock) begin
      upd_start_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         dim_ff <= DIM_RESET;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            dim_ff <= csr_wr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  node_ff <= req.node_index;
                  row_ff <= req.node_index;
                  sub_ff <= ROW_SUB0;
                  u_ff <= req.vel_u;
                  v_ff <= req.vel_v;
                  w_ff <= (dim_ff == DIM_2D) ? '0 : req.vel_w;
                  p_ff <= req.pressure;
                  x_ff[Q_U] <= MEAN_W'(req.vel_u);
                  x_ff[Q_V] <= MEAN_W'(req.vel_v);
                  x_ff[Q_W] <= (dim_ff == DIM_2D) ? '0 : MEAN_W'(req.vel_w);
                  x_ff[Q_P] <= MEAN_W'(req.pressure);
                  last_ff <= req.last_of_step;
                  two_d_ff <= (dim_ff == DIM_2D);
                  prep_ff <= '0;
                  state_ff <= S_PROD;
               end
            end
            S_PROD: begin
               // products floor-shifted to 16 fraction bits
               if (prep_ff < PREP_W'(NPROD)) begin
                  x_ff[prod_q] <= MEAN_W'(prod_full >>> 16);
               end
               row_ff <= row_next;
               sub_ff <= sub_ff >> 1;
               prep_ff <= prep_ff + 1'b1;
               if (prep_ff == PREP_W'(NODE_W - 1)) begin
                  row_base_ff <= ADDR_W'(row_next * QUANTITIES);
                  q_ff <= '0;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               if (!cur_slot.used) begin
                  mean_ff[q_ff] <= '0;
                  if (q_ff == Q_LAST) begin
                     state_ff <= S_RESP;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     q_ff <= q_ff + 1'b1;
                  end
               end else begin
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               upd_start_ff <= 1'b1;
               state_ff <= S_UPD;
            end
            S_UPD: begin
               if (upd_done) begin
                  mean_ff[q_ff] <= upd_res;
                  if (q_ff == Q_LAST) begin
                     state_ff <= S_RESP;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     q_ff <= q_ff + 1'b1;
                     state_ff <= S_READ;
                  end
               end
            end
            S_RESP: begin
               if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (last_ff && step_ff != '1) begin
                     step_ff <= step_ff + 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.out_node = node_ff;
   assign rsp.mean_u = mean_ff[Q_U];
   assign rsp.mean_v = mean_ff[Q_V];
   assign rsp.mean_w = mean_ff[Q_W];
   assign rsp.mean_uu = mean_ff[Q_UU];
   assign rsp.mean_vv = mean_ff[Q_VV];
   assign rsp.mean_ww = mean_ff[Q_WW];
   assign rsp.mean_uv = mean_ff[Q_UV];
   assign rsp.mean_uw = mean_ff[Q_UW];
   assign rsp.mean_vw = mean_ff[Q_VW];
   assign rsp.mean_p = mean_ff[Q_P];
   assign rsp.mean_pp = mean_ff[Q_PP];

   // no new request while a response is pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req.ready)
      else $error("request accepted with response pending");
   // response valid only in the response state
   a_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_RESP)
      else $error("response valid outside response state");
   // step counter never wraps
   a_sat: assert property (@(posedge clock) disable iff (reset)
      ($past(step_ff) == '1 && !$past(reset)) |-> step_ff == '1)
      else $error("step counter wrapped");
endmodule

// ===== hw/rtl/pnrms_ram.sv =====
// generic single port ram with registered read
module pnrms_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_ff <= mem_ff[addr];
   end

   assign rd_data = rd_ff;
endmodule

// ===== hw/rtl/pnrms_update.sv =====
// one mean update: 64x32 multiply-accumulate in two partial products then bit-serial 96/33 divide
module pnrms_update (
   input  logic                          clock,
   input  logic                          reset,
   input  pnrms_pkg::upd_req_type        req,
   output logic                          done,
   output logic [pnrms_pkg::MEAN_W-1:0]  result
);
   import pnrms_pkg::*;

   localparam int NUM_W = 96;
   localparam int DIV_W = COUNT_W + 1;
   localparam int CNT_W = $clog2(NUM_W + 1);

   typedef enum logic [2:0] {S_IDLE, S_MUL0, S_MUL1, S_ADD, S_DIV, S_SAT} state_type;

   state_type          state_ff;
   logic [MEAN_W-1:0]  om_ff, xm_ff;
   logic               on_ff, xn_ff, rn_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [DIV_W:0]     rem_ff;
   logic [CNT_W-1:0]   bit_ff;
   logic [MEAN_W-1:0]  res_ff;
   logic               done_ff;
   logic [63:0]        pp;
   logic [DIV_W:0]     rem_sh;
   logic [DIV_W:0]     diff;
   logic [MEAN_W-1:0]  lim;

   // 32x32 partial product per cycle
   assign pp = (state_ff == S_MUL0) ? om_ff[31:0] * cnt_ff : om_ff[63:32] * cnt_ff;
   assign rem_sh = {rem_ff[DIV_W-1:0], num_ff[NUM_W-1]};
   assign diff = rem_sh - {1'b0, {1'b0, cnt_ff} + 33'd1};
   assign lim = rn_ff ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req.start) begin
                  on_ff <= req.old_mean[63];
                  xn_ff <= req.sample[63];
                  om_ff <= req.old_mean[63] ? -req.old_mean : req.old_mean;
                  xm_ff <= req.sample[63] ? -req.sample : req.sample;
                  cnt_ff <= req.count;
                  num_ff <= '0;
                  if (req.count == '0) begin
                     res_ff <= req.sample;
                     done_ff <= 1'b1;
                  end else begin
                     state_ff <= S_MUL0;
                  end
               end
            end
            S_MUL0: begin
               num_ff <= {32'd0, pp};
               state_ff <= S_MUL1;
            end
            S_MUL1: begin
               num_ff <= num_ff + {pp, 32'd0};
               state_ff <= S_ADD;
            end
            S_ADD: begin
               if (on_ff == xn_ff) begin
                  num_ff <= num_ff + {32'd0, xm_ff};
                  rn_ff <= on_ff;
               end else if (num_ff >= {32'd0, xm_ff}) begin
                  num_ff <= num_ff - {32'd0, xm_ff};
                  rn_ff <= on_ff;
               end else begin
                  num_ff <= {32'd0, xm_ff} - num_ff;
                  rn_ff <= xn_ff;
               end
               rem_ff <= '0;
               bit_ff <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               // restoring division, one quotient bit per cycle
               if (!diff[DIV_W]) begin
                  rem_ff <= diff;
                  num_ff <= {num_ff[NUM_W-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  num_ff <= {num_ff[NUM_W-2:0], 1'b0};
               end
               bit_ff <= bit_ff + 1'b1;
               if (bit_ff == CNT_W'(NUM_W - 1)) begin
                  state_ff <= S_SAT;
               end
            end
            S_SAT: begin
               if (num_ff[NUM_W-1:MEAN_W] != '0 || num_ff[MEAN_W-1:0] > lim) begin
                  res_ff <= rn_ff ? -lim : lim;
               end else begin
                  res_ff <= rn_ff ? -num_ff[MEAN_W-1:0] : num_ff[MEAN_W-1:0];
               end
               done_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign result = res_ff;
endmodule
